// File: hdl/hbf_pkg.sv
// Shared types, constants and byte functions for the hashed bit filter.
// Used by the top module, hbf_aes_round and hbf_mod; depends on nothing.
`timescale 1ns / 1ps
package hbf_pkg;

    localparam int MAP_BYTES   = 32768;
    localparam int MAP_AW      = $clog2(MAP_BYTES);
    localparam int BIT_W       = MAP_AW + 3;
    localparam int NBITS_W     = BIT_W + 1;
    localparam int MAX_ELEMENT_BYTES = 65536;
    localparam int LEN_W       = 17;
    localparam int CFG_W       = 16;
    localparam int CHUNK_PIECES = 5;
    localparam int PIECE_IDX_W = $clog2(CHUNK_PIECES);
    localparam int CHUNK_WORDS = 2 * CHUNK_PIECES;
    localparam int SLOT_W      = $clog2(CHUNK_WORDS);
    localparam int STEP_W      = 3;
    localparam logic [63:0] SEED_CONST = 64'h1337133713371337;

    typedef enum logic [2:0] {
        ST_CLR, ST_IDLE, ST_LOAD, ST_ABS, ST_FIN, ST_MOD, ST_RD, ST_TST
    } hbf_state_t;

    typedef struct packed {
        logic               start;
        logic [63:0]        dividend;
        logic [NBITS_W-1:0] divisor;
    } hbf_div_req_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// File: hdl/hashed_bit_filter_test_and_set.sv
// Sequence: a non-final word is loaded, then the block returns to idle; a word closing a
// chunk or the element is absorbed by the shared AES round; the final word adds 4 rounds,
// the remainder unit and a bitmap read-modify-write. One word is in flight at a time.
// Reset: synchronous, active low; afterwards a clearing pass writes every bitmap byte,
// during which no item is accepted. Configuration writes are registered in cfg_reg.
// Depends on hbf_pkg, hbf_ram, hbf_aes_round, hbf_mod.
`timescale 1ns / 1ps
module hashed_bit_filter_test_and_set (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,    // map_bytes_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,        // [63:0] data_word, [80:64] element_length, zero pad
    input  logic        s_tlast,        // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // [17:0] bit_position, zero pad
    output logic        m_tuser         // already_seen
);

    localparam int BW = hbf_pkg::BIT_W;
    localparam int CFG_W_T = hbf_pkg::CFG_W;

    hbf_pkg::hbf_state_t state_reg, state_next;

    logic [hbf_pkg::CFG_W-1:0]       cfg_reg;
    logic [63:0]                     word_reg, word_next;
    logic [hbf_pkg::LEN_W-1:0]       len_reg, len_next;
    logic                            last_reg, last_next;
    logic [63:0]                     seed_hi_reg, seed_hi_next;
    logic [127:0]                    hash_reg, hash_next;
    logic [127:0]                    p0_reg, p0_next;
    logic [127:0]                    chunk_reg [hbf_pkg::CHUNK_PIECES];
    logic [127:0]                    chunk_next [hbf_pkg::CHUNK_PIECES];
    logic [hbf_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [hbf_pkg::LEN_W-1:0]       taken_reg, taken_next;
    logic [hbf_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [hbf_pkg::MAP_AW-1:0]      clr_reg, clr_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            seen_reg, seen_next;
    logic [BW-1:0]                   pos_reg, pos_next;

    logic [hbf_pkg::LEN_W-1:0]       len_in;
    logic [127:0]                    seed;
    logic [127:0]                    aes_in, aes_key, aes_out;
    logic [hbf_pkg::PIECE_IDX_W-1:0] piece_idx;
    logic [127:0]                    piece;
    logic [CFG_W_T-1:0]              nb_eff;
    logic [hbf_pkg::NBITS_W-1:0]     nbits;
    hbf_pkg::hbf_div_req_t           div_req;
    logic                            div_done;
    logic [BW-1:0]                   bit_idx;
    logic                            ram_we;
    logic [hbf_pkg::MAP_AW-1:0]      ram_waddr, ram_raddr;
    logic [7:0]                      ram_wdata, ram_rdata;
    logic [7:0]                      bit_mask;

    // Saturate the incoming length
    assign len_in = (s_tdata[80:64] > hbf_pkg::LEN_W'(hbf_pkg::MAX_ELEMENT_BYTES))
                  ? hbf_pkg::LEN_W'(hbf_pkg::MAX_ELEMENT_BYTES) : s_tdata[80:64];

    // Clamp bytes in use to the range from 1 to the bitmap size
    always_comb begin
        if (cfg_reg == '0) begin
            nb_eff = CFG_W_T'(1);
        end else if ({1'b0, cfg_reg} > (CFG_W_T + 1)'(hbf_pkg::MAP_BYTES)) begin
            nb_eff = CFG_W_T'(hbf_pkg::MAP_BYTES);
        end else begin
            nb_eff = cfg_reg;
        end
    end
    assign nbits = hbf_pkg::NBITS_W'({nb_eff, 3'b000});

    assign seed      = {seed_hi_reg, hbf_pkg::SEED_CONST};
    assign piece_idx = (step_reg < hbf_pkg::STEP_W'(hbf_pkg::CHUNK_PIECES))
                     ? step_reg[hbf_pkg::PIECE_IDX_W-1:0] : '0;
    assign piece     = chunk_reg[piece_idx] ^ seed;

    // Select operands of the shared round unit
    always_comb begin
        aes_in  = p0_reg;
        aes_key = seed;
        if (state_reg == hbf_pkg::ST_ABS) begin
            if (step_reg == 3'd6) begin
                aes_in  = hash_reg;
                aes_key = p0_reg;
            end else if (step_reg == 3'd5) begin
                aes_key = seed;
            end else begin
                aes_key = piece;
            end
        end else if (state_reg == hbf_pkg::ST_FIN) begin
            aes_in = hash_reg;
        end
    end

    hbf_aes_round u_round (
        .state_in  (aes_in),
        .round_key (aes_key),
        .state_out (aes_out)
    );

    hbf_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .done      (div_done),
        .remainder (bit_idx)
    );

    hbf_ram #(.WIDTH(8), .DEPTH(hbf_pkg::MAP_BYTES)) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign bit_mask  = 8'(1) << bit_idx[2:0];
    assign ram_raddr = bit_idx[BW-1:3];

    // Sequencer: next state and datapath updates
    always_comb begin
        logic                       init;
        logic                       store;
        logic                       absorb;
        logic [hbf_pkg::LEN_W-1:0]  remain;
        logic [hbf_pkg::SLOT_W-1:0] slot_eff;
        logic [63:0]                masked;
        logic [63:0]                seed_hi_eff;

        state_next   = state_reg;
        word_next    = word_reg;
        len_next     = len_reg;
        last_next    = last_reg;
        seed_hi_next = seed_hi_reg;
        hash_next    = hash_reg;
        p0_next      = p0_reg;
        chunk_next   = chunk_reg;
        slot_next    = slot_reg;
        taken_next   = taken_reg;
        step_next    = step_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg;
        seen_next    = seen_reg;
        pos_next     = pos_reg;
        s_tready     = 1'b0;
        div_req      = '{start: 1'b0, dividend: aes_out[63:0] ^ aes_out[127:64],
                         divisor: nbits};
        ram_we       = 1'b0;
        ram_waddr    = clr_reg;
        ram_wdata    = 8'h00;

        init        = (taken_reg == '0);
        store       = (taken_reg < len_reg);
        remain      = len_reg - taken_reg;
        slot_eff    = init ? '0 : slot_reg;
        absorb      = store && (slot_eff == hbf_pkg::SLOT_W'(hbf_pkg::CHUNK_WORDS - 1) ||
                                remain <= hbf_pkg::LEN_W'(8) || last_reg);
        seed_hi_eff = hbf_pkg::SEED_CONST + 64'(len_reg) + 64'd1;
        for (int i = 0; i < 8; i++) begin
            masked[8*i +: 8] = (remain > hbf_pkg::LEN_W'(i)) ? word_reg[8*i +: 8] : 8'h00;
        end

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            hbf_pkg::ST_CLR: begin
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == hbf_pkg::MAP_AW'(hbf_pkg::MAP_BYTES - 1)) begin
                    state_next = hbf_pkg::ST_IDLE;
                end
            end
            hbf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    word_next  = s_tdata[63:0];
                    len_next   = len_in;
                    last_next  = s_tlast;
                    state_next = hbf_pkg::ST_LOAD;
                end
            end
            hbf_pkg::ST_LOAD: begin
                // Start a new element
                if (init) begin
                    seed_hi_next = seed_hi_eff;
                    hash_next    = {seed_hi_eff, hbf_pkg::SEED_CONST};
                    for (int i = 0; i < hbf_pkg::CHUNK_PIECES; i++) begin
                        chunk_next[i] = '0;
                    end
                end
                // Place the word in its chunk slot
                if (store) begin
                    chunk_next[slot_eff[hbf_pkg::SLOT_W-1:1]][64*slot_eff[0] +: 64] = masked;
                    slot_next  = (slot_eff == hbf_pkg::SLOT_W'(hbf_pkg::CHUNK_WORDS - 1))
                               ? '0 : slot_eff + 1'b1;
                    taken_next = taken_reg + hbf_pkg::LEN_W'(8);
                end
                step_next = '0;
                if (absorb) begin
                    state_next = hbf_pkg::ST_ABS;
                end else if (last_reg) begin
                    state_next = hbf_pkg::ST_FIN;
                end else begin
                    state_next = hbf_pkg::ST_IDLE;
                end
            end
            hbf_pkg::ST_ABS: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd0) begin
                    p0_next = piece;
                end else if (step_reg == 3'd6) begin
                    hash_next = aes_out;
                    for (int i = 0; i < hbf_pkg::CHUNK_PIECES; i++) begin
                        chunk_next[i] = '0;
                    end
                    step_next  = '0;
                    state_next = last_reg ? hbf_pkg::ST_FIN : hbf_pkg::ST_IDLE;
                end else begin
                    p0_next = aes_out;
                end
            end
            hbf_pkg::ST_FIN: begin
                hash_next = aes_out;
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd3) begin
                    div_req.start = 1'b1;
                    state_next    = hbf_pkg::ST_MOD;
                end
            end
            hbf_pkg::ST_MOD: begin
                if (div_done) begin
                    state_next = hbf_pkg::ST_RD;
                end
            end
            hbf_pkg::ST_RD: begin
                state_next = hbf_pkg::ST_TST;
            end
            hbf_pkg::ST_TST: begin
                // Test and set once the output register is free
                if (!m_valid_reg || m_tready) begin
                    ram_we       = 1'b1;
                    ram_waddr    = bit_idx[BW-1:3];
                    ram_wdata    = ram_rdata | bit_mask;
                    seen_next    = (ram_rdata & bit_mask) != 8'h00;
                    pos_next     = bit_idx;
                    m_valid_next = 1'b1;
                    taken_next   = '0;
                    state_next   = hbf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hbf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hbf_pkg::ST_CLR;
            cfg_reg     <= hbf_pkg::CFG_W'(hbf_pkg::MAP_BYTES);
            taken_reg   <= '0;
            slot_reg    <= '0;
            step_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            taken_reg   <= taken_next;
            slot_reg    <= slot_next;
            step_reg    <= step_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
        end
        word_reg    <= word_next;
        len_reg     <= len_next;
        last_reg    <= last_next;
        seed_hi_reg <= seed_hi_next;
        hash_reg    <= hash_next;
        p0_reg      <= p0_next;
        chunk_reg   <= chunk_next;
        seen_reg    <= seen_next;
        pos_reg     <= pos_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 24'(pos_reg);
    assign m_tuser  = seen_reg;

`ifndef ASSERT_OFF
    a_result_from_test: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == hbf_pkg::ST_TST))
        else $error("result raised outside test-and-set");
    a_bit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hbf_pkg::ST_TST) |-> ({1'b0, bit_idx} < nbits))
        else $error("bit index beyond bitmap bits in use");
    a_taken_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        taken_reg[2:0] == 3'b000)
        else $error("byte offset not word aligned");
    a_clear_writes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hbf_pkg::ST_CLR) |-> (ram_we && ram_wdata == 8'h00 && !s_tready))
        else $error("clearing pass misbehaves");
`endif

endmodule

// File: hdl/hbf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module hbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/hbf_aes_round.sv
// One AES encryption round (ShiftRows, SubBytes, MixColumns, key XOR), combinational.
// Depends on hbf_pkg for the S-box and xtime.
`timescale 1ns / 1ps
module hbf_aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    output logic [127:0] state_out
);

    logic [7:0] sb [16];
    logic [7:0] mc [16];

    // Shift rows and substitute
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[r + 4 * c] = hbf_pkg::SBOX[state_in[8 * (r + 4 * ((c + r) % 4)) +: 8]];
            end
        end
    end

    // Mix columns and add key
    always_comb begin
        logic [7:0] x;
        x = 8'h00;
        for (int c = 0; c < 4; c++) begin
            x = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
            mc[4*c]   = sb[4*c]   ^ x ^ hbf_pkg::xtime(sb[4*c]   ^ sb[4*c+1]);
            mc[4*c+1] = sb[4*c+1] ^ x ^ hbf_pkg::xtime(sb[4*c+1] ^ sb[4*c+2]);
            mc[4*c+2] = sb[4*c+2] ^ x ^ hbf_pkg::xtime(sb[4*c+2] ^ sb[4*c+3]);
            mc[4*c+3] = sb[4*c+3] ^ x ^ hbf_pkg::xtime(sb[4*c+3] ^ sb[4*c]);
        end
        for (int i = 0; i < 16; i++) begin
            state_out[8*i +: 8] = mc[i] ^ round_key[8*i +: 8];
        end
    end

endmodule

// File: hdl/hbf_mod.sv
// Bit-serial restoring remainder unit: 64-bit dividend modulo the bitmap bit count.
// Depends on hbf_pkg for widths and the request struct.
`timescale 1ns / 1ps
module hbf_mod (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hbf_pkg::hbf_div_req_t       req,
    output logic                        done,
    output logic [hbf_pkg::BIT_W-1:0]   remainder
);

    logic [63:0]                  quo_reg, quo_next;
    logic [hbf_pkg::NBITS_W-1:0]  rem_reg, rem_next;
    logic [hbf_pkg::NBITS_W-1:0]  div_reg, div_next;
    logic [5:0]                   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [hbf_pkg::NBITS_W:0]    trial;

    // One quotient bit per cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = hbf_pkg::NBITS_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[hbf_pkg::NBITS_W-1:0];
            end
            quo_next = {quo_reg[62:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[hbf_pkg::BIT_W-1:0];

endmodule
